### hdl/prfl_pkg.sv
// Shared constants for the page replacement unit.
package prfl_pkg;

  localparam int unsigned PAGES_DEF  = 1024;
  localparam int unsigned FRAMES_DEF = 64;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned AGE_W   = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IW  = 2;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_POLICY      = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PAGE_SHIFT  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ADDR_BITS   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_FRAMES_USED = 2'd3;

  // policy codes
  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  localparam logic [4:0] SHIFT_RST  = 5'd12;
  localparam logic [5:0] ABITS_RST  = 6'd22;
  localparam logic [6:0] FRAMES_RST = 7'd64;

endpackage

### hdl/prfl_if.sv
// Item channels of the page replacement unit.
interface prfl_in_if;
  logic                         valid;
  logic                         ready;
  logic [prfl_pkg::ADDR_W-1:0]  virtual_address;
  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

interface prfl_out_if #(
  parameter int unsigned FW = 6,
  parameter int unsigned PW = 10
);
  logic                          valid;
  logic                          ready;
  logic                          fault;
  logic [FW-1:0]                 frame;
  logic                          evicted;
  logic [PW-1:0]                 evicted_page;
  logic [prfl_pkg::COUNT_W-1:0]  fault_count;
  logic                          out_of_range;
  modport source (output valid, output fault, output frame, output evicted,
                  output evicted_page, output fault_count, output out_of_range,
                  input ready);
  modport sink   (input valid, input fault, input frame, input evicted,
                  input evicted_page, input fault_count, input out_of_range,
                  output ready);
endinterface

### hdl/prfl_ram.sv
// Single-port-write, registered-read synchronous memory.
module prfl_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hdl/page_replacement_fifo_lru_unit.sv
// Page replacement unit (FIFO / LRU). After reset a clearing pass sweeps the
// whole page table before the first item is taken. An item reads the page table;
// a miss then reads, evicts and rewrites the chosen frame and marks the page. Under
// LRU an aging walk over the filled frames follows, and a miss with all frames
// full adds a victim search over the frames in use, both one frame a cycle
// through the frame table port. A new item is taken while the last result waits.
module page_replacement_fifo_lru_unit #(
  parameter int unsigned PAGES  = prfl_pkg::PAGES_DEF,
  parameter int unsigned FRAMES = prfl_pkg::FRAMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [prfl_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [prfl_pkg::CFG_W-1:0]  cfg_data_i,
  prfl_in_if.sink                     in_i,
  prfl_out_if.source                  out_o
);
  import prfl_pkg::*;

  localparam int unsigned PW  = $clog2(PAGES);
  localparam int unsigned FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned FCW = $clog2(FRAMES + 1);
  localparam int unsigned MW  = PW + AGE_W;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_PRD  = 9'b000000100,
    S_SRCH = 9'b000001000,
    S_FRD  = 9'b000010000,
    S_FEV  = 9'b000100000,
    S_UPD  = 9'b001000000,
    S_WALK = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic       policy_q;
  logic [4:0] shift_q;
  logic [5:0] abits_q;
  logic [6:0] fiu_q;

  logic [PW-1:0]      page_q, page_d, clr_q, clr_d;
  logic [FW-1:0]      frame_q, frame_d, next_q, next_d, best_idx_q, best_idx_d;
  logic [FW-1:0]      fm_raddr_q, fm_raddr;
  logic               fm_rvalid_q;
  logic               fault_q, fault_d, evict_q, evict_d, oor_q, oor_d;
  logic [PW-1:0]      evp_q, evp_d;
  logic [FCW-1:0]     filled_q, filled_d, cnt_q, cnt_d;
  logic [COUNT_W-1:0] ftot_q, ftot_d;
  logic [AGE_W-1:0]   best_age_q, best_age_d;
  logic               out_valid_q, out_valid_d, out_load;

  logic               o_fault_q, o_evict_q, o_oor_q;
  logic [FW-1:0]      o_frame_q;
  logic [PW-1:0]      o_evp_q;
  logic [COUNT_W-1:0] o_ftot_q;

  // page table: {valid, frame}; frame table: {page, age}
  logic          pm_we, pm_re;
  logic [PW-1:0] pm_waddr, pm_raddr;
  logic [FW:0]   pm_wdata, pm_rdata;
  logic          fm_we, fm_re;
  logic [FW-1:0] fm_waddr;
  logic [MW-1:0] fm_wdata, fm_rdata;

  prfl_ram #(.DEPTH(PAGES), .AW(PW), .DW(FW + 1)) u_page_tbl (
    .clk_i, .we_i(pm_we), .waddr_i(pm_waddr), .wdata_i(pm_wdata),
    .re_i(pm_re), .raddr_i(pm_raddr), .rdata_o(pm_rdata)
  );

  prfl_ram #(.DEPTH(FRAMES), .AW(FW), .DW(MW)) u_frame_tbl (
    .clk_i, .we_i(fm_we), .waddr_i(fm_waddr), .wdata_i(fm_wdata),
    .re_i(fm_re), .raddr_i(fm_raddr), .rdata_o(fm_rdata)
  );

  // address decode
  logic [ADDR_W-1:0] va, page_full;
  logic [5:0]        ab;
  logic              in_rng, accept;

  assign va        = in_i.virtual_address;
  assign page_full = va >> shift_q;
  assign ab        = (abits_q == 6'd0) ? 6'd1 : abits_q;
  assign in_rng    = ((ab >= 6'd32) || ((va >> ab) == '0)) && (page_full < ADDR_W'(PAGES));
  assign in_i.ready = (state_q == S_IDLE);
  assign accept    = in_i.valid && in_i.ready;

  logic [FCW-1:0] nf, nf_m1;
  assign nf    = (fiu_q == 7'd0) ? FCW'(1) :
                 (32'(fiu_q) > 32'(FRAMES)) ? FCW'(FRAMES) : FCW'(fiu_q);
  assign nf_m1 = nf - FCW'(1);

  logic [FW-1:0] fifo_frame, fifo_next;
  assign fifo_frame = (FCW'(next_q) < nf) ? next_q : '0;
  assign fifo_next  = ((FCW'(fifo_frame) + FCW'(1)) >= nf) ? '0 : fifo_frame + FW'(1);

  logic [PW-1:0]    fm_page;
  logic [AGE_W-1:0] fm_age, new_age;
  logic             take;
  assign fm_page = fm_rdata[AGE_W +: PW];
  assign fm_age  = fm_rdata[AGE_W-1:0];
  // accessed frame ends the walk at one, the rest age with saturation
  assign new_age = (fm_raddr_q == frame_q) ? AGE_W'(1) :
                   (fm_age == '1) ? fm_age : fm_age + AGE_W'(1);
  assign take    = (fm_raddr_q == '0) || (fm_age > best_age_q);

  always_comb begin
    state_d    = state_q;
    page_d     = page_q;
    clr_d      = clr_q;
    frame_d    = frame_q;
    next_d     = next_q;
    best_idx_d = best_idx_q;
    best_age_d = best_age_q;
    fault_d    = fault_q;
    evict_d    = evict_q;
    evp_d      = evp_q;
    oor_d      = oor_q;
    filled_d   = filled_q;
    cnt_d      = cnt_q;
    ftot_d     = ftot_q;
    out_load   = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    pm_we    = 1'b0;
    pm_waddr = page_q;
    pm_wdata = '0;
    pm_re    = 1'b0;
    pm_raddr = page_full[PW-1:0];
    fm_re    = 1'b0;
    fm_raddr = cnt_q[FW-1:0];
    fm_we    = 1'b0;
    fm_waddr = fm_raddr_q;
    fm_wdata = '0;

    unique case (state_q)
      S_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_q;
        clr_d    = clr_q + PW'(1);
        if (clr_q == PW'(PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          page_d  = page_full[PW-1:0];
          evict_d = 1'b0;
          evp_d   = '0;
          if (!in_rng) begin
            fault_d = 1'b0;
            frame_d = '0;
            oor_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            pm_re   = 1'b1;
            oor_d   = 1'b0;
            state_d = S_PRD;
          end
        end
      end
      S_PRD: begin
        cnt_d = '0;
        if (pm_rdata[FW]) begin
          fault_d = 1'b0;
          frame_d = pm_rdata[FW-1:0];
          state_d = (policy_q == POL_LRU) ? S_WALK : S_DONE;
        end else begin
          fault_d = 1'b1;
          if (policy_q == POL_FIFO) begin
            frame_d = fifo_frame;
            next_d  = fifo_next;
            state_d = S_FRD;
          end else if (filled_q < nf) begin
            frame_d = filled_q[FW-1:0];
            state_d = S_FRD;
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (cnt_q < nf) begin
          fm_re = 1'b1;
          cnt_d = cnt_q + FCW'(1);
        end
        if (fm_rvalid_q) begin
          if (take) begin
            best_idx_d = fm_raddr_q;
            best_age_d = fm_age;
          end
          if (fm_raddr_q == nf_m1[FW-1:0]) begin
            frame_d = take ? fm_raddr_q : best_idx_q;
            state_d = S_FRD;
          end
        end
      end
      S_FRD: begin
        fm_re    = 1'b1;
        fm_raddr = frame_q;
        state_d  = S_FEV;
      end
      S_FEV: begin
        if (FCW'(frame_q) < filled_q) begin
          evict_d  = 1'b1;
          evp_d    = fm_page;
          pm_we    = 1'b1;
          pm_waddr = fm_page;
          pm_wdata = '0;
        end else begin
          filled_d = FCW'(frame_q) + FCW'(1);
        end
        fm_we    = 1'b1;
        fm_waddr = frame_q;
        fm_wdata = {page_q, {AGE_W{1'b0}}};
        if (ftot_q != '1) ftot_d = ftot_q + COUNT_W'(1);
        state_d  = S_UPD;
      end
      S_UPD: begin
        pm_we    = 1'b1;
        pm_waddr = page_q;
        pm_wdata = {1'b1, frame_q};
        cnt_d    = '0;
        state_d  = (policy_q == POL_LRU) ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (cnt_q < filled_q) begin
          fm_re = 1'b1;
          cnt_d = cnt_q + FCW'(1);
        end
        if (fm_rvalid_q) begin
          fm_we    = 1'b1;
          fm_wdata = {fm_page, new_age};
        end
        if ((cnt_q >= filled_q) && !fm_rvalid_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      next_q      <= '0;
      filled_q    <= '0;
      ftot_q      <= '0;
      cnt_q       <= '0;
      fm_rvalid_q <= 1'b0;
      out_valid_q <= 1'b0;
      policy_q    <= POL_FIFO;
      shift_q     <= SHIFT_RST;
      abits_q     <= ABITS_RST;
      fiu_q       <= FRAMES_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      next_q      <= next_d;
      filled_q    <= filled_d;
      ftot_q      <= ftot_d;
      cnt_q       <= cnt_d;
      fm_rvalid_q <= fm_re;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POLICY:      policy_q <= cfg_data_i[0];
          CFG_PAGE_SHIFT:  shift_q  <= cfg_data_i[4:0];
          CFG_ADDR_BITS:   abits_q  <= cfg_data_i[5:0];
          CFG_FRAMES_USED: fiu_q    <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    frame_q    <= frame_d;
    best_idx_q <= best_idx_d;
    best_age_q <= best_age_d;
    fault_q    <= fault_d;
    evict_q    <= evict_d;
    evp_q      <= evp_d;
    oor_q      <= oor_d;
    if (fm_re) fm_raddr_q <= fm_raddr;
    if (out_load) begin
      o_fault_q <= fault_q;
      o_frame_q <= frame_q;
      o_evict_q <= evict_q;
      o_evp_q   <= evp_q;
      o_ftot_q  <= ftot_q;
      o_oor_q   <= oor_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.fault        = o_fault_q;
  assign out_o.frame        = o_frame_q;
  assign out_o.evicted      = o_evict_q;
  assign out_o.evicted_page = o_evp_q;
  assign out_o.fault_count  = o_ftot_q;
  assign out_o.out_of_range = o_oor_q;
endmodule
